// File: hdl/pid_pkg.sv
// Shared types and constants for the positional PID controller.
// Holds the item structs, the command structs, opcodes, register indexes and reset values.
// No dependencies.
package pid_pkg;

  // Fixed field widths of the item and configuration interfaces.
  localparam int GAIN_W     = 24;
  localparam int LIMIT_W    = 31;
  localparam int DT_W       = 16;
  localparam int DT_FRAC    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // Item opcodes.
  localparam logic [1:0] OP_ERR_DIFF   = 2'd0;
  localparam logic [1:0] OP_ERR_DIRECT = 2'd1;
  localparam logic [1:0] OP_CLEAR      = 2'd2;
  localparam logic [1:0] OP_NONE       = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIM    = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = 24'd65536;
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST = 24'd0;
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST = 24'd0;
  localparam logic [LIMIT_W-1:0] INTEG_LIM_RST  = 31'd19660800;
  localparam logic [LIMIT_W-1:0] OUT_LIM_RST    = 31'd52428800;

  // Which product the shared multiplier is forming.
  localparam logic [1:0] MUL_KI = 2'd0;
  localparam logic [1:0] MUL_DT = 2'd1;
  localparam logic [1:0] MUL_KP = 2'd2;
  localparam logic [1:0] MUL_KD = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] setpoint;
    logic signed [31:0] feedback;
    logic signed [31:0] error_in;
    logic [DT_W-1:0]    step_time;
  } pid_in_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               integral_clamped;
    logic               output_clamped;
  } pid_out_t;

  typedef struct packed {
    logic setup;
    logic step_lo;
    logic step_hi;
    logic step_add;
  } pid_mul_cmd_t;

  typedef struct packed {
    logic         load;
    pid_mul_cmd_t mul;
    logic [1:0]   mul_sel;
    logic         mul_wb;
    logic         integ_upd;
    logic         sum_p;
    logic         sum_d;
    logic         commit;
  } pid_cmd_t;

endpackage

// File: hdl/pid_mul.sv
// Shared sign-magnitude multiplier of the PID datapath.
// Forms (|a| * b) >> shift over two half-width partial products, then saturates.
// Depends on pid_pkg.
module pid_mul #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  pid_pkg::pid_mul_cmd_t        cmd,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic [pid_pkg::GAIN_W-1:0]   b,
  input  logic                         use_dt,
  output logic signed [DATA_WIDTH-1:0] result
);
  import pid_pkg::*;

  localparam int HW  = (DATA_WIDTH + 1) / 2;
  localparam int MPW = HW + GAIN_W;
  localparam int PW  = DATA_WIDTH + GAIN_W;
  localparam logic [PW-1:0]         CAP    = PW'(1) << (DATA_WIDTH - 1);
  localparam logic [DATA_WIDTH-1:0] CAP_DW = CAP[DATA_WIDTH-1:0];
  localparam logic [DATA_WIDTH-1:0] MAXPOS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  logic [DATA_WIDTH-1:0] mag;
  logic                  neg;
  logic [GAIN_W-1:0]     b_q;
  logic                  dt_sel;
  logic [MPW-1:0]        prod;
  logic [PW-1:0]         acc;
  logic [HW-1:0]         opnd;
  logic [PW-1:0]         shifted;
  logic [DATA_WIDTH-1:0] mag_r;

  // The high half is used in the step_hi cycle, the low half otherwise.
  assign opnd = cmd.step_hi ? HW'(mag >> HW) : mag[HW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      neg    <= a[DATA_WIDTH-1];
      mag    <= a[DATA_WIDTH-1] ? DATA_WIDTH'(-a) : DATA_WIDTH'(a);
      b_q    <= b;
      dt_sel <= use_dt;
    end
    if (cmd.step_lo || cmd.step_hi) begin
      prod <= MPW'(opnd) * MPW'(b_q);
    end
    if (cmd.step_hi) begin
      acc <= PW'(prod);
    end else if (cmd.step_add) begin
      acc <= acc + (PW'(prod) << HW);
    end
  end

  always_comb begin
    shifted = dt_sel ? (acc >> DT_FRAC) : (acc >> FRAC_BITS);
    mag_r   = (shifted > CAP) ? CAP_DW : shifted[DATA_WIDTH-1:0];
    if (neg) begin
      result = $signed(DATA_WIDTH'(-mag_r));
    end else if (shifted >= CAP) begin
      result = $signed(MAXPOS);
    end else begin
      result = $signed(shifted[DATA_WIDTH-1:0]);
    end
  end

endmodule

// File: hdl/pid_dp.sv
// Datapath of the PID controller: configuration registers, error, integral and sums.
// Instantiates pid_mul; driven by commands from pid_ctrl.
// Depends on pid_pkg.
module pid_dp #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pid_pkg::pid_cmd_t                   cmd,
  input  pid_pkg::pid_in_t                    item,
  input  logic                                wr_en,
  input  logic [pid_pkg::CFG_IDX_W-1:0]       wr_index,
  input  logic [pid_pkg::CFG_DATA_W-1:0]      wr_data,
  output pid_pkg::pid_out_t                   result
);
  import pid_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int CW = ((DW > 32) ? DW : 32) + 2;
  localparam logic signed [CW-1:0] MAXV = $signed({{(CW-DW+1){1'b0}}, {(DW-1){1'b1}}});
  localparam logic signed [CW-1:0] MINV = $signed({{(CW-DW+1){1'b1}}, {(DW-1){1'b0}}});

  function automatic logic signed [CW-1:0] ext(input logic signed [DW-1:0] x);
    return $signed({{(CW-DW){x[DW-1]}}, x});
  endfunction

  function automatic logic signed [CW-1:0] ext32(input logic signed [31:0] x);
    return $signed({{(CW-32){x[31]}}, x});
  endfunction

  function automatic logic signed [DW-1:0] sat(input logic signed [CW-1:0] v);
    if (v > MAXV) begin
      return $signed(MAXV[DW-1:0]);
    end else if (v < MINV) begin
      return $signed(MINV[DW-1:0]);
    end
    return $signed(v[DW-1:0]);
  endfunction

  // Returns the hit flag above the clamped value.
  function automatic logic [DW:0] clamp_sym(input logic signed [DW-1:0] v,
                                            input logic [LIMIT_W-1:0] lim);
    logic signed [CW-1:0] vx;
    logic signed [CW-1:0] lx;
    logic signed [CW-1:0] nx;
    vx = ext(v);
    lx = $signed({{(CW-LIMIT_W){1'b0}}, lim});
    nx = -lx;
    if (vx > lx) begin
      return {1'b1, lx[DW-1:0]};
    end else if (vx < nx) begin
      return {1'b1, nx[DW-1:0]};
    end
    return {1'b0, v};
  endfunction

  logic [GAIN_W-1:0]     prop_gain;
  logic [GAIN_W-1:0]     integ_gain;
  logic [GAIN_W-1:0]     deriv_gain;
  logic [LIMIT_W-1:0]    integral_limit;
  logic [LIMIT_W-1:0]    output_limit;

  logic signed [DW-1:0]  err;
  logic signed [DW-1:0]  diff;
  logic signed [DW-1:0]  ki_term;
  logic signed [DW-1:0]  inc;
  logic signed [DW-1:0]  p_term;
  logic signed [DW-1:0]  d_term;
  logic signed [DW-1:0]  sum;
  logic signed [DW-1:0]  integral_sum;
  logic signed [DW-1:0]  previous_error;
  logic [DT_W-1:0]       dt_q;
  logic                  ihit;

  logic signed [DW-1:0]  mul_a;
  logic [GAIN_W-1:0]     mul_b;
  logic signed [DW-1:0]  mul_res;
  logic signed [DW-1:0]  err_new;
  logic [DW:0]           integ_c;
  logic [DW:0]           out_c;
  logic signed [CW-1:0]  drive_x;

  always_comb begin
    case (cmd.mul_sel)
      MUL_KI:  begin mul_a = err;     mul_b = integ_gain;     end
      MUL_DT:  begin mul_a = ki_term; mul_b = GAIN_W'(dt_q);  end
      MUL_KP:  begin mul_a = err;     mul_b = prop_gain;      end
      default: begin mul_a = diff;    mul_b = deriv_gain;     end
    endcase
  end

  pid_mul #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mul (
    .clk    (clk),
    .cmd    (cmd.mul),
    .a      (mul_a),
    .b      (mul_b),
    .use_dt (cmd.mul_sel == MUL_DT),
    .result (mul_res)
  );

  assign err_new = (item.opcode == OP_ERR_DIFF) ?
                   sat(ext32(item.setpoint) - ext32(item.feedback)) :
                   sat(ext32(item.error_in));
  assign integ_c = clamp_sym(sat(ext(integral_sum) + ext(inc)), integral_limit);
  assign out_c   = clamp_sym(sum, output_limit);
  assign drive_x = ext($signed(out_c[DW-1:0]));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain      <= PROP_GAIN_RST;
      integ_gain     <= INTEG_GAIN_RST;
      deriv_gain     <= DERIV_GAIN_RST;
      integral_limit <= INTEG_LIM_RST;
      output_limit   <= OUT_LIM_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PROP_GAIN:  prop_gain      <= wr_data[GAIN_W-1:0];
        REG_INTEG_GAIN: integ_gain     <= wr_data[GAIN_W-1:0];
        REG_DERIV_GAIN: deriv_gain     <= wr_data[GAIN_W-1:0];
        REG_INTEG_LIM:  integral_limit <= wr_data[LIMIT_W-1:0];
        REG_OUT_LIM:    output_limit   <= wr_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Controller state carried across items.
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum   <= '0;
      previous_error <= '0;
    end else begin
      if (cmd.load && item.opcode == OP_CLEAR) begin
        integral_sum <= '0;
      end else if (cmd.integ_upd) begin
        integral_sum <= $signed(integ_c[DW-1:0]);
      end
      if (cmd.commit) begin
        previous_error <= err;
      end
    end
  end

  // Working registers of one step.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err  <= err_new;
      dt_q <= item.step_time;
    end
    if (cmd.mul_wb) begin
      case (cmd.mul_sel)
        MUL_KI:  ki_term <= mul_res;
        MUL_DT:  inc     <= mul_res;
        MUL_KP:  p_term  <= mul_res;
        default: d_term  <= mul_res;
      endcase
    end
    if (cmd.integ_upd) begin
      ihit <= integ_c[DW];
      diff <= sat(ext(err) - ext(previous_error));
    end
    if (cmd.sum_p) begin
      sum <= sat(ext(p_term) + ext(integral_sum));
    end else if (cmd.sum_d) begin
      sum <= sat(ext(sum) + ext(d_term));
    end
    if (cmd.commit) begin
      result.drive            <= $signed(drive_x[31:0]);
      result.integral_clamped <= ihit;
      result.output_clamped   <= out_c[DW];
    end
  end

endmodule

// File: hdl/pid_ctrl.sv
// Sequencing state machine of the PID controller.
// Steps the datapath through the four shared products and the final sums.
// Depends on pid_pkg.
module pid_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [1:0]        item_opcode,
  output logic              result_valid,
  input  logic              result_stall,
  output pid_pkg::pid_cmd_t cmd
);
  import pid_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SETUP = 4'd1;
  localparam logic [3:0] S_MLO   = 4'd2;
  localparam logic [3:0] S_MHI   = 4'd3;
  localparam logic [3:0] S_MADD  = 4'd4;
  localparam logic [3:0] S_MWB   = 4'd5;
  localparam logic [3:0] S_INTEG = 4'd6;
  localparam logic [3:0] S_SUM_P = 4'd7;
  localparam logic [3:0] S_SUM_D = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [1:0] sel;
  logic [1:0] sel_next;
  logic       accept;
  logic       commit;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign commit     = (state == S_DONE) && (!result_valid || !result_stall);

  always_comb begin
    state_next  = state;
    sel_next    = sel;
    cmd         = '0;
    cmd.mul_sel = sel;
    cmd.commit  = commit;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (item_opcode == OP_ERR_DIFF || item_opcode == OP_ERR_DIRECT) begin
            state_next = S_SETUP;
            sel_next   = MUL_KI;
          end
        end
      end
      S_SETUP: begin
        cmd.mul.setup = 1'b1;
        state_next    = S_MLO;
      end
      S_MLO: begin
        cmd.mul.step_lo = 1'b1;
        state_next      = S_MHI;
      end
      S_MHI: begin
        cmd.mul.step_hi = 1'b1;
        state_next      = S_MADD;
      end
      S_MADD: begin
        cmd.mul.step_add = 1'b1;
        state_next       = S_MWB;
      end
      S_MWB: begin
        cmd.mul_wb = 1'b1;
        if (sel == MUL_DT) begin
          state_next = S_INTEG;
        end else if (sel == MUL_KD) begin
          state_next = S_SUM_P;
        end else begin
          sel_next   = sel + 2'd1;
          state_next = S_SETUP;
        end
      end
      S_INTEG: begin
        cmd.integ_upd = 1'b1;
        sel_next      = MUL_KP;
        state_next    = S_SETUP;
      end
      S_SUM_P: begin
        cmd.sum_p  = 1'b1;
        state_next = S_SUM_D;
      end
      S_SUM_D: begin
        cmd.sum_d  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sel          <= MUL_KI;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      if (commit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_commit_shows_result: assert property (@(posedge clk) disable iff (rst)
    commit |=> result_valid)
    else $error("committed result not presented");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_DONE)
    else $error("result appeared outside the final step");

  a_no_work_for_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && (item_opcode == OP_CLEAR || item_opcode == OP_NONE)) |=> state == S_IDLE)
    else $error("clear or empty opcode started a computation");

  a_integ_after_dt: assert property (@(posedge clk) disable iff (rst)
    state == S_INTEG |-> (sel == MUL_DT && $past(state) == S_MWB))
    else $error("integral update out of order");

endmodule

// File: hdl/positional_pid_controller.sv
// Top level of the positional PID controller with integral clamp.
// Instantiates pid_ctrl and pid_dp (which holds pid_mul).
// Depends on pid_pkg.

// Each item runs one positional PID step in signed fixed point with FRAC_BITS
// fraction bits and DATA_WIDTH-bit saturating intermediates. Opcode OP_ERR_DIFF
// takes setpoint minus feedback as the error, OP_ERR_DIRECT takes error_in, and
// both return one result: the drive, clamped to plus or minus output_limit, with
// flags that tell whether the integral or the drive was clamped in that step.
// OP_CLEAR zeroes the integral and OP_NONE does nothing; neither returns a
// result, and both free the input channel in the cycle after their transfer.
// The four products (ki*error, that times dt, kp*error, kd*error difference)
// run one after another on a single shared multiplier of about half the data
// width by 24 bits, each through setup, low-half, high-half, add and write-back
// steps. The integral update follows the dt product, and two saturating adds
// and the output clamp follow the last product. No new item is taken until the
// computing item's result is committed. The result sits in an output register,
// so the next item is taken while an earlier result still waits on
// result_stall; only the commit of the following result waits for it.
// Configuration registers are written through wr_en, wr_index and wr_data while
// the block is idle, which the user must ensure; an index beyond the list is ignored.
module positional_pid_controller #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  pid_pkg::pid_in_t               item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output pid_pkg::pid_out_t              result,
  input  logic                           wr_en,
  input  logic [pid_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [pid_pkg::CFG_DATA_W-1:0] wr_data
);
  import pid_pkg::*;

  // Command bundle from the sequencer to the datapath.
  pid_cmd_t cmd;

  pid_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item_opcode  (item.opcode),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd)
  );

  // The datapath also holds the configuration registers and the result
  // register, which is loaded only when the previous result has been taken.
  pid_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .item     (item),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .result   (result)
  );

endmodule
